FILE: hw/rtl/sfs_pkg.sv
package sfs_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int MAX_SAMPLES = 4096;
	localparam int CNT_W       = 13;
	localparam int SUM_W       = 29;
	localparam int SQS_W       = 43;
	localparam int MAGS_W      = 28;
	localparam int CROSS_W     = 12;
	localparam int FRAC_W      = 8;

	localparam int MEAN_W = 24;
	localparam int VAR_W  = 40;
	localparam int SD_W   = 24;
	localparam int POW_W  = 39;
	localparam int MAG_W  = 24;
	localparam int STAT_W = 2;

	// shared add/subtract unit and its operand registers
	localparam int ALU_W = 55;
	localparam int SH_W  = 64;
	localparam int OPB_W = SQS_W;
	localparam int STEP_W = 6;

	localparam int DIV_LAST  = SH_W - 1;
	localparam int MULN_LAST = CNT_W - 1;
	localparam int MULB_LAST = MAGS_W - 1;
	localparam int SQRT_LAST = SD_W - 1;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_SINGLE   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd3;

endpackage

FILE: hw/rtl/speech_frame_statistics.sv
// Sample words are taken one per cycle while no frame result is being computed.
// The word with last set starts the result sequence on one shared add/subtract unit:
// after any wait for the previous result to leave the output register: mean, power and
// magnitude, then variance and root for two or more samples. sample_stall is high
// throughout. The result then sits in the output register until taken.
// Reset clears the accumulators, the sequencer and the output valid; no result pending.
module speech_frame_statistics (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [sfs_pkg::SAMPLE_W-1:0] sample,
	input  logic                                last,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [sfs_pkg::MEAN_W-1:0]   mean_q8,
	output logic        [sfs_pkg::VAR_W-1:0]    variance_q8,
	output logic        [sfs_pkg::SD_W-1:0]     std_dev_q8,
	output logic        [sfs_pkg::POW_W-1:0]    power_q8,
	output logic        [sfs_pkg::MAG_W-1:0]    magnitude_q8,
	output logic        [sfs_pkg::CROSS_W-1:0]  zero_crossings,
	output logic        [sfs_pkg::CNT_W-1:0]    frame_length,
	output logic        [sfs_pkg::STAT_W-1:0]   status
);
	import sfs_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_START    = 4'd1;
	localparam logic [3:0] S_DIV_MEAN = 4'd2;
	localparam logic [3:0] S_DIV_POW  = 4'd3;
	localparam logic [3:0] S_DIV_MAG  = 4'd4;
	localparam logic [3:0] S_MUL_A    = 4'd5;
	localparam logic [3:0] S_MUL_B    = 4'd6;
	localparam logic [3:0] S_SUB_D    = 4'd7;
	localparam logic [3:0] S_MUL_N    = 4'd8;
	localparam logic [3:0] S_DIV_VAR  = 4'd9;
	localparam logic [3:0] S_SQRT     = 4'd10;
	localparam logic [3:0] S_DONE     = 4'd11;

	logic [3:0]          state_q;
	logic [STEP_W-1:0]   cnt_q;
	logic                out_valid_q;

	logic [CNT_W-1:0]    n_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SQS_W-1:0]    sqs_q;
	logic [MAGS_W-1:0]   mags_q;
	logic [SAMPLE_W-1:0] prev_q;
	logic [CROSS_W-1:0]  cross_q;
	logic                ovf_q;

	logic [ALU_W-1:0]    acc_q;
	logic [ALU_W-1:0]    tmp_q;
	logic [SH_W-1:0]     sh_q;
	logic [OPB_W-1:0]    opb_q;

	logic [MEAN_W-1:0]   mean_q8_q;
	logic [VAR_W-1:0]    variance_q8_q;
	logic [SD_W-1:0]     std_dev_q8_q;
	logic [POW_W-1:0]    power_q8_q;
	logic [MAG_W-1:0]    magnitude_q8_q;
	logic [CROSS_W-1:0]  zero_crossings_q;
	logic [CNT_W-1:0]    frame_length_q;
	logic [STAT_W-1:0]   status_q;

	logic                in_take;
	logic                room;
	logic [SAMPLE_W-1:0] smag;
	logic [2*SAMPLE_W-1:0] ssq;
	logic                x_neg, x_pos, p_neg, p_pos;
	logic                sum_neg;
	logic [SUM_W-1:0]    sum_abs;
	logic [MAGS_W-1:0]   am;
	logic [STAT_W-1:0]   stat_nx;

	logic [ALU_W-1:0]    alu_a, alu_b;
	logic                alu_sub;
	logic [ALU_W:0]      alu_sum;
	logic                alu_carry;
	logic [ALU_W-1:0]    acc_step;
	logic [SH_W-1:0]     sh_div;
	logic [SD_W-1:0]     root_step;
	logic                op_end;

	assign sample_stall = (state_q != S_IDLE);
	assign in_take      = sample_valid && !sample_stall;
	assign room         = (n_q < CNT_W'(MAX_SAMPLES));

	assign smag  = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;
	assign ssq   = (2*SAMPLE_W)'(smag) * (2*SAMPLE_W)'(smag);
	assign x_neg = sample[SAMPLE_W-1];
	assign x_pos = !sample[SAMPLE_W-1] && (|sample);
	assign p_neg = prev_q[SAMPLE_W-1];
	assign p_pos = !prev_q[SAMPLE_W-1] && (|prev_q);

	assign sum_neg = sum_q[SUM_W-1];
	assign sum_abs = sum_neg ? (SUM_W'(0) - sum_q) : sum_q;
	assign am      = sum_abs[MAGS_W-1:0];

	always_comb begin
		if (n_q == '0) begin
			stat_nx = STAT_EMPTY;
		end else if (ovf_q) begin
			stat_nx = STAT_OVERFLOW;
		end else if (n_q == CNT_W'(1)) begin
			stat_nx = STAT_SINGLE;
		end else begin
			stat_nx = STAT_OK;
		end
	end

	// shared unit: divide step, multiply step, subtract or root step
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			S_DIV_MEAN, S_DIV_POW, S_DIV_MAG, S_DIV_VAR: begin
				alu_a   = {acc_q[ALU_W-2:0], sh_q[SH_W-1]};
				alu_b   = ALU_W'(opb_q);
				alu_sub = 1'b1;
			end
			S_MUL_A, S_MUL_B, S_MUL_N: begin
				alu_a = {acc_q[ALU_W-2:0], 1'b0};
				alu_b = sh_q[SH_W-1] ? ALU_W'(opb_q) : '0;
			end
			S_SUB_D: begin
				alu_a   = tmp_q;
				alu_b   = acc_q;
				alu_sub = 1'b1;
			end
			S_SQRT: begin
				alu_a   = {acc_q[ALU_W-3:0], sh_q[SH_W-1:SH_W-2]};
				alu_b   = ALU_W'({std_dev_q8_q, 2'b01});
				alu_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
	                 + (ALU_W+1)'(alu_sub);
	assign alu_carry = alu_sum[ALU_W];
	// keep the partial remainder when the trial subtract borrows
	assign acc_step  = (alu_sub && !alu_carry) ? alu_a : alu_sum[ALU_W-1:0];
	assign sh_div    = {sh_q[SH_W-2:0], alu_carry};
	assign root_step = {std_dev_q8_q[SD_W-2:0], alu_carry};

	always_comb begin
		case (state_q)
			S_DIV_MEAN, S_DIV_POW, S_DIV_MAG, S_DIV_VAR:
				op_end = (cnt_q == STEP_W'(DIV_LAST));
			S_MUL_A, S_MUL_N:
				op_end = (cnt_q == STEP_W'(MULN_LAST));
			S_MUL_B:
				op_end = (cnt_q == STEP_W'(MULB_LAST));
			S_SQRT:
				op_end = (cnt_q == STEP_W'(SQRT_LAST));
			default:
				op_end = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			n_q         <= '0;
			sum_q       <= '0;
			sqs_q       <= '0;
			mags_q      <= '0;
			prev_q      <= '0;
			cross_q     <= '0;
			ovf_q       <= 1'b0;
		end else begin
			if (state_q == S_DONE) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			cnt_q <= (op_end || state_q == S_IDLE || state_q == S_START
			          || state_q == S_SUB_D || state_q == S_DONE) ? '0 : cnt_q + STEP_W'(1);
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (room) begin
							if (n_q != '0 && ((x_neg && p_pos) || (x_pos && p_neg))
							    && !(&cross_q)) begin
								cross_q <= cross_q + CROSS_W'(1);
							end
							sum_q  <= sum_q + SUM_W'(sample);
							sqs_q  <= sqs_q + SQS_W'(ssq);
							mags_q <= mags_q + MAGS_W'(smag);
							prev_q <= sample;
							n_q    <= n_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last) begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					// hold until the previous result has left the output register
					if (!out_valid_q) begin
						state_q <= (n_q == '0) ? S_DONE : S_DIV_MEAN;
					end
				end
				S_DIV_MEAN: if (op_end) state_q <= S_DIV_POW;
				S_DIV_POW:  if (op_end) state_q <= S_DIV_MAG;
				S_DIV_MAG: begin
					if (op_end) begin
						state_q <= (n_q < CNT_W'(2)) ? S_DONE : S_MUL_A;
					end
				end
				S_MUL_A:   if (op_end) state_q <= S_MUL_B;
				S_MUL_B:   if (op_end) state_q <= S_SUB_D;
				S_SUB_D:   state_q <= S_MUL_N;
				S_MUL_N:   if (op_end) state_q <= S_DIV_VAR;
				S_DIV_VAR: if (op_end) state_q <= S_SQRT;
				S_SQRT:    if (op_end) state_q <= S_DONE;
				S_DONE: begin
					n_q         <= '0;
					sum_q       <= '0;
					sqs_q       <= '0;
					mags_q      <= '0;
					cross_q     <= '0;
					ovf_q       <= 1'b0;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_START: begin
				// leave a pending result untouched on the outputs
				if (!out_valid_q) begin
					acc_q          <= '0;
					sh_q           <= SH_W'({am, FRAC_W'(0)});
					opb_q          <= OPB_W'(n_q);
					mean_q8_q      <= '0;
					variance_q8_q  <= '0;
					std_dev_q8_q   <= '0;
					power_q8_q     <= '0;
					magnitude_q8_q <= '0;
				end
			end
			S_DIV_MEAN, S_DIV_POW, S_DIV_MAG: begin
				if (!op_end) begin
					acc_q <= acc_step;
					sh_q  <= sh_div;
				end else begin
					acc_q <= '0;
					if (state_q == S_DIV_MEAN) begin
						mean_q8_q <= sum_neg ? (MEAN_W'(0) - sh_div[MEAN_W-1:0])
						                     : sh_div[MEAN_W-1:0];
						sh_q      <= SH_W'({sqs_q, FRAC_W'(0)});
					end else if (state_q == S_DIV_POW) begin
						power_q8_q <= sh_div[POW_W-1:0];
						sh_q       <= SH_W'({mags_q, FRAC_W'(0)});
					end else begin
						magnitude_q8_q <= sh_div[MAG_W-1:0];
						sh_q           <= {n_q, (SH_W-CNT_W)'(0)};
						opb_q          <= sqs_q;
					end
				end
			end
			S_MUL_A, S_MUL_B, S_MUL_N: begin
				if (op_end && state_q == S_MUL_A) begin
					tmp_q <= acc_step;
					acc_q <= '0;
					sh_q  <= {am, (SH_W-MAGS_W)'(0)};
					opb_q <= OPB_W'(am);
				end else if (op_end && state_q == S_MUL_N) begin
					acc_q <= '0;
					sh_q  <= SH_W'({tmp_q, FRAC_W'(0)});
					opb_q <= OPB_W'(acc_step);
				end else begin
					acc_q <= acc_step;
					sh_q  <= {sh_q[SH_W-2:0], 1'b0};
				end
			end
			S_SUB_D: begin
				// clamp a negative difference to zero
				tmp_q <= alu_carry ? alu_sum[ALU_W-1:0] : '0;
				acc_q <= '0;
				sh_q  <= {n_q, (SH_W-CNT_W)'(0)};
				opb_q <= OPB_W'(n_q - CNT_W'(1));
			end
			S_DIV_VAR: begin
				if (op_end) begin
					variance_q8_q <= sh_div[VAR_W-1:0];
					acc_q         <= '0;
					sh_q          <= {sh_div[VAR_W-1:0], (SH_W-VAR_W)'(0)};
					std_dev_q8_q  <= '0;
				end else begin
					acc_q <= acc_step;
					sh_q  <= sh_div;
				end
			end
			S_SQRT: begin
				acc_q        <= acc_step;
				sh_q         <= {sh_q[SH_W-3:0], 2'b00};
				std_dev_q8_q <= root_step;
			end
			S_DONE: begin
				zero_crossings_q <= cross_q;
				frame_length_q   <= n_q;
				status_q         <= stat_nx;
			end
			default: begin
			end
		endcase
	end

	assign result_valid   = out_valid_q;
	assign mean_q8        = mean_q8_q;
	assign variance_q8    = variance_q8_q;
	assign std_dev_q8     = std_dev_q8_q;
	assign power_q8       = power_q8_q;
	assign magnitude_q8   = magnitude_q8_q;
	assign zero_crossings = zero_crossings_q;
	assign frame_length   = frame_length_q;
	assign status         = status_q;

endmodule
